FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PLIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// An implication checked in the same cycle.
`define PLIC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/plic_pkg.sv
// ----------------------------------------------------------------------------
// plic_pkg
// Sizes, register map constants and request codes of the interrupt controller.
// ----------------------------------------------------------------------------
package plic_pkg;

    // Sources, including the reserved source zero, and contexts.
    localparam int NUM_SOURCES       = 32;
    localparam int NUM_CONTEXTS      = 2;
    localparam int PRIORITY_BITS_DEF = 3;

    localparam int SRC_W = $clog2(NUM_SOURCES);
    localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

    // Word fields.
    localparam int REQ_W  = 2;
    localparam int ADDR_W = 26;
    localparam int DATA_W = 32;
    localparam int IRQ_W  = 2;

    localparam int IN_FIELDS_W  = ADDR_W + DATA_W + SRC_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_W + IRQ_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Request kinds carried in tuser.
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RAISE = 2'd2;

    // Register map.
    localparam logic [ADDR_W-1:0] PEND_BASE = 26'h000_1000;
    localparam logic [ADDR_W-1:0] EN_BASE   = 26'h000_2000;
    localparam logic [ADDR_W-1:0] CTX_BASE  = 26'h020_0000;
    localparam int                EN_LSB    = 7;   // 0x80 bytes per enable block
    localparam int                CTX_LSB   = 12;  // 0x1000 bytes per context block
    localparam logic [CTX_LSB-1:0] THRESH_OFF = 12'h000;
    localparam logic [CTX_LSB-1:0] CLAIM_OFF  = 12'h004;

    // Source zero never gets an enable bit.
    localparam logic [NUM_SOURCES-1:0] EN_MASK = ~NUM_SOURCES'(1);

endpackage

FILE: rtl/platform_interrupt_controller_top.sv
// ----------------------------------------------------------------------------
// platform_interrupt_controller_top
// Platform-level interrupt controller with a word-addressed register window.
// ----------------------------------------------------------------------------
// Each input word is a bus read, a bus write or a source raise (tuser), and
// each one yields exactly one output word: the read data (register value, or
// the claimed id on a claim read, zero otherwise) together with one interrupt
// line per context that is high when that context has a claimable source above
// its threshold once the request has taken effect. A request passes through
// S_IDLE to take the word, S_EXEC to apply writes and raises, S_SCAN to sweep
// the source priority memory through its single registered read port (one
// entry per cycle), and S_DONE to apply a claim and load the output register
// once that register is free. The sweep serves both contexts at once. The
// next word is taken while the previous result still waits in the output
// register. No clearing pass is needed after reset: each priority entry has a
// valid bit and reads as zero until written.
`include "assert_macros.svh"

module platform_interrupt_controller_top #(
    parameter int PRIORITY_BITS = plic_pkg::PRIORITY_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request side.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: address [25:0], write_data [57:26], source_id [62:58], zero [63]
    input  logic [plic_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: req_type [1:0]
    input  logic [plic_pkg::REQ_W-1:0]       s_axis_tuser,
    // Response side.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: read_data [31:0], context_irq [33:32], zero [39:34]
    output logic [plic_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import plic_pkg::*;

    localparam int IDX_W = $clog2(NUM_SOURCES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    // What a decoded address points at.
    typedef enum logic [2:0] {
        K_NONE,
        K_PRIO,
        K_PEND,
        K_ENAB,
        K_THRESH,
        K_CLAIM
    } t_kind;

    t_state                   r_state;

    // Request held for the whole transaction.
    logic [REQ_W-1:0]         r_req;
    logic [ADDR_W-1:0]        r_addr;
    logic [DATA_W-1:0]        r_wdata;
    logic [SRC_W-1:0]         r_src;

    // Interrupt state kept in flops.
    logic [NUM_SOURCES-1:0]   r_pending;
    logic [NUM_SOURCES-1:0]   r_in_service;
    logic [NUM_SOURCES-1:0]   r_enable [NUM_CONTEXTS];
    logic [PRIORITY_BITS-1:0] r_thresh [NUM_CONTEXTS];

    // Source priority memory with a valid bit per entry.
    logic [PRIORITY_BITS-1:0] r_prio_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]   r_prio_vld;
    logic [PRIORITY_BITS-1:0] r_mem_q;
    logic                     r_mem_vld_q;

    // Sweep state.
    logic [IDX_W-1:0]         r_idx;
    logic                     r_rd_vld;
    logic [SRC_W-1:0]         r_rd_id;
    logic [PRIORITY_BITS-1:0] r_prio_rd;
    logic [NUM_CONTEXTS-1:0]  r_found;
    logic [NUM_CONTEXTS-1:0]  r_multi;
    logic [SRC_W-1:0]         r_best_id [NUM_CONTEXTS];
    logic [PRIORITY_BITS-1:0] r_best_p  [NUM_CONTEXTS];

    // Output register.
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_rdata;
    logic [IRQ_W-1:0]         r_out_irq;

    // Decode of the held request.
    logic [ADDR_W-1:0]        w_addr;
    logic [ADDR_W-1:0]        w_en_off;
    logic [ADDR_W-1:0]        w_cx_off;
    t_kind                    w_kind;
    logic [CTX_W-1:0]         w_ctx;
    logic [SRC_W-1:0]         w_prio_id;
    logic                     w_cmpl_ok;
    logic                     w_mem_we;
    logic [SRC_W-1:0]         w_mem_raddr;
    logic [PRIORITY_BITS-1:0] w_prio_q;
    logic [NUM_CONTEXTS-1:0]  w_cand;
    logic [NUM_CONTEXTS-1:0]  w_better;
    logic [SRC_W-1:0]         w_claim_id;
    logic [DATA_W-1:0]        w_rdata;
    logic [IRQ_W-1:0]         w_irq;

    // The two low address bits are ignored throughout.
    assign w_addr    = {r_addr[ADDR_W-1:2], 2'b00};
    assign w_en_off  = w_addr - EN_BASE;
    assign w_cx_off  = w_addr - CTX_BASE;
    assign w_prio_id = w_addr[SRC_W+1:2];

    always_comb begin
        w_kind = K_NONE;
        w_ctx  = '0;
        if (w_addr < PEND_BASE) begin
            // Priority words; source zero and sources past the end are unmapped.
            if (w_addr[CTX_LSB-1:SRC_W+2] == '0 && w_prio_id != '0) begin
                w_kind = K_PRIO;
            end
        end else if (w_addr < EN_BASE) begin
            if (w_addr[CTX_LSB-1:2] == '0) begin
                w_kind = K_PEND;
            end
        end else if (w_addr < CTX_BASE) begin
            if (w_en_off[ADDR_W-1:EN_LSB] < (ADDR_W-EN_LSB)'(NUM_CONTEXTS)
                    && w_en_off[EN_LSB-1:2] == '0) begin
                w_kind = K_ENAB;
                w_ctx  = w_en_off[EN_LSB +: CTX_W];
            end
        end else begin
            if (w_cx_off[ADDR_W-1:CTX_LSB] < (ADDR_W-CTX_LSB)'(NUM_CONTEXTS)) begin
                w_ctx = w_cx_off[CTX_LSB +: CTX_W];
                if (w_cx_off[CTX_LSB-1:0] == THRESH_OFF) begin
                    w_kind = K_THRESH;
                end else if (w_cx_off[CTX_LSB-1:0] == CLAIM_OFF) begin
                    w_kind = K_CLAIM;
                end
            end
        end
    end

    // A complete only counts for a nonzero, in-range id that the context enables.
    assign w_cmpl_ok = (r_wdata[DATA_W-1:SRC_W] == '0) && (r_wdata[SRC_W-1:0] != '0)
                       && r_enable[w_ctx][r_wdata[SRC_W-1:0]];

    assign w_mem_we    = (r_state == S_EXEC) && (r_req == REQ_WRITE) && (w_kind == K_PRIO);
    assign w_mem_raddr = (r_state == S_SCAN) ? r_idx[SRC_W-1:0] : w_prio_id;
    assign w_prio_q    = r_mem_vld_q ? r_mem_q : '0;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_prio_mem[w_prio_id] <= r_wdata[PRIORITY_BITS-1:0];
        end
        r_mem_q <= r_prio_mem[w_mem_raddr];
    end

    // One entry of the sweep is judged for every context in parallel. The best
    // value starts at the threshold, and a strict compare keeps the lowest id
    // on a tie since ids arrive in ascending order.
    always_comb begin
        for (int c = 0; c < NUM_CONTEXTS; c++) begin
            w_cand[c]   = r_rd_vld && r_pending[r_rd_id] && r_enable[c][r_rd_id]
                          && (w_prio_q > r_thresh[c]);
            w_better[c] = w_cand[c] && (w_prio_q > r_best_p[c]);
        end
    end

    assign w_claim_id = (r_req == REQ_READ && w_kind == K_CLAIM) ? r_best_id[w_ctx] : '0;

    // A claim removes one pending source. A context keeps its line when it saw
    // two or more candidates, or when its single candidate was not the one
    // taken.
    always_comb begin
        w_irq = '0;
        for (int c = 0; c < IRQ_W; c++) begin
            if (c < NUM_CONTEXTS) begin
                w_irq[c] = r_found[c] && (r_multi[c] || r_best_id[c] != w_claim_id);
            end
        end
    end

    always_comb begin
        w_rdata = '0;
        if (r_req == REQ_READ) begin
            case (w_kind)
                K_PRIO:   w_rdata = DATA_W'(r_prio_rd);
                K_PEND:   w_rdata = DATA_W'(r_pending);
                K_ENAB:   w_rdata = DATA_W'(r_enable[w_ctx]);
                K_THRESH: w_rdata = DATA_W'(r_thresh[w_ctx]);
                K_CLAIM:  w_rdata = DATA_W'(w_claim_id);
                default:  w_rdata = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pending    <= '0;
            r_in_service <= '0;
            r_prio_vld   <= '0;
            r_rd_vld     <= 1'b0;
            r_found      <= '0;
            r_multi      <= '0;
            r_out_valid  <= 1'b0;
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                r_enable[c] <= '0;
                r_thresh[c] <= '0;
            end
        end else begin
            r_mem_vld_q <= r_prio_vld[w_mem_raddr];
            // In the final state the output register is reloaded instead.
            if (m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req   <= s_axis_tuser;
                        r_addr  <= s_axis_tdata[ADDR_W-1:0];
                        r_wdata <= s_axis_tdata[ADDR_W +: DATA_W];
                        r_src   <= s_axis_tdata[ADDR_W+DATA_W +: SRC_W];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_req)
                        REQ_WRITE: begin
                            case (w_kind)
                                K_PRIO:   r_prio_vld[w_prio_id] <= 1'b1;
                                K_ENAB:   r_enable[w_ctx] <= r_wdata[NUM_SOURCES-1:0] & EN_MASK;
                                K_THRESH: r_thresh[w_ctx] <= r_wdata[PRIORITY_BITS-1:0];
                                K_CLAIM: begin
                                    if (w_cmpl_ok) begin
                                        r_in_service[r_wdata[SRC_W-1:0]] <= 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        REQ_RAISE: begin
                            if (r_src != '0 && !r_in_service[r_src]) begin
                                r_pending[r_src] <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_idx == '0) begin
                        // Memory output now holds the bus read of a priority word.
                        r_prio_rd <= w_prio_q;
                        r_found   <= '0;
                        r_multi   <= '0;
                        for (int c = 0; c < NUM_CONTEXTS; c++) begin
                            r_best_id[c] <= '0;
                            r_best_p[c]  <= r_thresh[c];
                        end
                    end else begin
                        for (int c = 0; c < NUM_CONTEXTS; c++) begin
                            if (w_cand[c]) begin
                                r_found[c] <= 1'b1;
                                if (r_found[c]) begin
                                    r_multi[c] <= 1'b1;
                                end
                                if (w_better[c]) begin
                                    r_best_id[c] <= r_rd_id;
                                    r_best_p[c]  <= w_prio_q;
                                end
                            end
                        end
                    end
                    r_rd_vld <= (r_idx < IDX_W'(NUM_SOURCES));
                    r_rd_id  <= r_idx[SRC_W-1:0];
                    if (r_idx == IDX_W'(NUM_SOURCES)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_rdata <= w_rdata;
                        r_out_irq   <= w_irq;
                        if (w_claim_id != '0) begin
                            r_pending[w_claim_id]    <= 1'b0;
                            r_in_service[w_claim_id] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), r_out_irq, r_out_rdata};

    // A source is never pending and in service at once.
    `PLIC_ASSERT(a_pend_isvc_excl, (r_pending & r_in_service) == '0, "pending and in-service overlap")
    // Source zero stays clear.
    `PLIC_ASSERT(a_src0_clear, !r_pending[0] && !r_in_service[0], "source zero became active")

    for (genvar g = 0; g < NUM_CONTEXTS; g++) begin : g_ctx_chk
        // A found candidate always names a real source.
        `PLIC_ASSERT_IMP(a_found_id, r_state == S_DONE && r_found[g], r_best_id[g] != '0, "candidate without id")
    end

endmodule
